// File: hdl/din99_pkg.sv
// Shared constants, coefficient tables and latencies for the DIN99 converter.
`default_nettype none

package din99_pkg;

    // Default number of fraction bits on the pixel ports
    localparam int FRAC_BITS_DEF = 8;

    // Logarithm unit: argument minus one, argument, exponent and result widths
    localparam int LN_Q     = 30;
    localparam int LN_X_W   = 40;
    localparam int LN_Y_W   = 41;
    localparam int LN_K_W   = 4;
    localparam int LN_OUT_W = 34;
    localparam int LN_LAT   = LN_Q + 4;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Square root unit
    localparam int SQ_IN_W  = 64;
    localparam int SQ_OUT_W = 32;
    localparam int SQ_LAT   = SQ_OUT_W;

    // Unit vector divider: signed numerator, root as divisor, Q30 quotient
    localparam int DIV_NUM_W = 35;
    localparam int DIV_Q     = 30;
    localparam int DIV_LAT   = SQ_OUT_W;

    // Rounding shift of the first rotation (Q30 coefficient to 16 extra bits)
    localparam int ROT_SH = 14;

    // Output limits
    localparam logic [14:0] L99_MAX = 15'h7FFF;
    localparam logic [14:0] AB_MAX  = 15'h3FFF;
    localparam logic [14:0] AB_MIN  = 15'h4000;

    // Per-variant coefficients: DIN99, DIN99b, DIN99c, DIN99d
    localparam logic [24:0] C1_Q16 [4] = '{
        25'd6914638, 25'd19901317, 25'd20817510, 25'd21313618};
    localparam logic [34:0] C2_Q40 [4] = '{
        35'd17372283719, 35'd4288095348, 35'd4068193023, 35'd3958241860};
    localparam logic signed [31:0] C4_Q30 [4] = '{
        32'sd751619277, 32'sd891205714, 32'sd1009317315, 32'sd1224065679};
    localparam logic [26:0] C6_Q30 [4] = '{
        27'd48318382, 27'd80530637, 27'd70866960, 27'd64424509};
    localparam logic [28:0] C58_Q24 [4] = '{
        29'd372827022, 29'd385875968, 29'd385875968, 29'd377487360};
    localparam logic signed [31:0] COS3_Q30 [4] = '{
        32'sd1032146887, 32'sd965072759, 32'sd1073741824, 32'sd690187940};
    localparam logic signed [31:0] SIN3_Q30 [4] = '{
        32'sd295963357, 32'sd470697435, 32'sd0, 32'sd822533958};
    localparam logic signed [31:0] COS7_Q30 [4] = '{
        32'sd1073741824, 32'sd965072759, 32'sd1073741824, 32'sd690187940};
    localparam logic signed [31:0] SIN7_Q30 [4] = '{
        32'sd0, 32'sd470697435, 32'sd0, 32'sd822533958};

endpackage

`default_nettype wire

// File: hdl/din99_delay.sv
// Enabled shift line that delays a data word by a fixed number of stages.
`default_nettype none

module din99_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [DEPTH];

    // Advance the line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

`default_nettype wire

// File: hdl/din99_ln.sv
// Pipelined natural log of (1 + x) in Q30, one squaring step per stage.
`default_nettype none

module din99_ln
    import din99_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [LN_X_W-1:0]   x,
    output logic [LN_OUT_W-1:0] ln_out
);

    localparam int NSQ = LN_Q;

    logic [LN_Y_W-1:0]   ya_reg, ya_next;
    logic [LN_K_W-1:0]   ka_reg, ka_next;
    logic [LN_Y_W-1:0]   yb_shift;
    logic [LN_Q:0]       ysq_reg [NSQ+1];
    logic [LN_Q-1:0]     fsq_reg [NSQ+1];
    logic [LN_K_W-1:0]   ksq_reg [NSQ+1];
    logic [2*LN_Q+1:0]   sq      [NSQ];
    logic [LN_Q+1:0]     sq_top  [NSQ];
    logic [LN_Q:0]       y_nx    [NSQ];
    logic [LN_Q-1:0]     f_nx    [NSQ];
    logic [63:0]         prod_reg, prod_next;
    logic [LN_OUT_W-1:0] ln_reg;
    logic [64:0]         rounded;

    // Form 1 + x and find the leading one above the binary point
    always_comb
    begin
        ya_next = {1'b0, x} + (LN_Y_W'(1) << LN_Q);
        ka_next = '0;
        for (int i = LN_Q; i < LN_Y_W; i++)
        begin
            if (ya_next[i])
            begin
                ka_next = LN_K_W'(i - LN_Q);
            end
        end
    end

    // Normalize into [1, 2)
    assign yb_shift = ya_reg >> ka_reg;

    // Square and renormalize, one fraction bit per stage
    always_comb
    begin
        for (int j = 0; j < NSQ; j++)
        begin
            sq[j]     = (2*LN_Q+2)'(ysq_reg[j]) * (2*LN_Q+2)'(ysq_reg[j]);
            sq_top[j] = sq[j][2*LN_Q+1:LN_Q];
            f_nx[j]   = fsq_reg[j];
            if (sq_top[j][LN_Q+1])
            begin
                y_nx[j]             = sq_top[j][LN_Q+1:1];
                f_nx[j][NSQ-1-j]    = 1'b1;
            end
            else
            begin
                y_nx[j] = sq_top[j][LN_Q:0];
            end
        end
    end

    // Scale log2 by ln 2
    assign prod_next = 64'({ksq_reg[NSQ], fsq_reg[NSQ]}) * 64'(LN2_Q30);
    assign rounded   = (65'(prod_reg) + (65'd1 << (LN_Q - 1))) >> LN_Q;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ya_reg     <= ya_next;
            ka_reg     <= ka_next;
            ysq_reg[0] <= yb_shift[LN_Q:0];
            fsq_reg[0] <= '0;
            ksq_reg[0] <= ka_reg;
            for (int j = 0; j < NSQ; j++)
            begin
                ysq_reg[j+1] <= y_nx[j];
                fsq_reg[j+1] <= f_nx[j];
                ksq_reg[j+1] <= ksq_reg[j];
            end
            prod_reg <= prod_next;
            ln_reg   <= rounded[LN_OUT_W-1:0];
        end
    end

    assign ln_out = ln_reg;

endmodule

`default_nettype wire

// File: hdl/din99_sqrt.sv
// Pipelined truncated integer square root, one result bit per stage.
`default_nettype none

module din99_sqrt
    import din99_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [SQ_IN_W-1:0]  v_in,
    output logic [SQ_OUT_W-1:0] root
);

    localparam int STEPS = SQ_OUT_W;

    logic [SQ_IN_W-1:0] v_reg [STEPS];
    logic [SQ_IN_W-1:0] r_reg [STEPS];
    logic [SQ_IN_W-1:0] v_cur [STEPS];
    logic [SQ_IN_W-1:0] r_cur [STEPS];
    logic [SQ_IN_W-1:0] v_nx  [STEPS];
    logic [SQ_IN_W-1:0] r_nx  [STEPS];
    logic [SQ_IN_W-1:0] bitv  [STEPS];
    logic [SQ_IN_W:0]   trial [STEPS];

    // Stage inputs
    always_comb
    begin
        v_cur[0] = v_in;
        r_cur[0] = '0;
        for (int i = 1; i < STEPS; i++)
        begin
            v_cur[i] = v_reg[i-1];
            r_cur[i] = r_reg[i-1];
        end
    end

    // Try one root bit per stage
    always_comb
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            bitv[i]  = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2*i);
            trial[i] = {1'b0, r_cur[i]} + {1'b0, bitv[i]};
            if ({1'b0, v_cur[i]} >= trial[i])
            begin
                v_nx[i] = v_cur[i] - trial[i][SQ_IN_W-1:0];
                r_nx[i] = (r_cur[i] >> 1) + bitv[i];
            end
            else
            begin
                v_nx[i] = v_cur[i];
                r_nx[i] = r_cur[i] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                v_reg[i] <= v_nx[i];
                r_reg[i] <= r_nx[i];
            end
        end
    end

    assign root = r_reg[STEPS-1][SQ_OUT_W-1:0];

endmodule

`default_nettype wire

// File: hdl/din99_div.sv
// Pipelined rounded divide of a signed coordinate by the root, Q30 quotient.
`default_nettype none

module din99_div
    import din99_pkg::*;
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [DIV_NUM_W-1:0] num,
    input  logic [SQ_OUT_W-1:0]         den,
    output logic [SQ_OUT_W-1:0]         quo,
    output logic                        neg
);

    localparam int STEPS = SQ_OUT_W;
    localparam int DW    = 2 * SQ_OUT_W;

    logic [DIV_NUM_W-1:0] mag;
    logic [DW-1:0]        dvd;
    logic [SQ_OUT_W-1:0]  rem_reg [STEPS];
    logic [SQ_OUT_W-1:0]  low_reg [STEPS];
    logic [SQ_OUT_W-1:0]  q_reg   [STEPS];
    logic [SQ_OUT_W-1:0]  den_reg [STEPS];
    logic                 neg_reg [STEPS];
    logic [SQ_OUT_W-1:0]  rem_cur [STEPS];
    logic [SQ_OUT_W-1:0]  low_cur [STEPS];
    logic [SQ_OUT_W-1:0]  q_cur   [STEPS];
    logic [SQ_OUT_W-1:0]  den_cur [STEPS];
    logic                 neg_cur [STEPS];
    logic [SQ_OUT_W:0]    r2      [STEPS];
    logic [SQ_OUT_W-1:0]  rem_nx  [STEPS];
    logic [SQ_OUT_W-1:0]  q_nx    [STEPS];

    // Form the rounded dividend; its upper half is already below the divisor
    assign mag = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
    assign dvd = {mag[DW-DIV_Q-1:0], {DIV_Q{1'b0}}} + DW'(den >> 1);

    always_comb
    begin
        rem_cur[0] = dvd[DW-1:SQ_OUT_W];
        low_cur[0] = dvd[SQ_OUT_W-1:0];
        q_cur[0]   = '0;
        den_cur[0] = den;
        neg_cur[0] = num[DIV_NUM_W-1];
        for (int i = 1; i < STEPS; i++)
        begin
            rem_cur[i] = rem_reg[i-1];
            low_cur[i] = low_reg[i-1];
            q_cur[i]   = q_reg[i-1];
            den_cur[i] = den_reg[i-1];
            neg_cur[i] = neg_reg[i-1];
        end
    end

    // One quotient bit per stage
    always_comb
    begin
        for (int i = 0; i < STEPS; i++)
        begin
            r2[i]   = {rem_cur[i], low_cur[i][STEPS-1-i]};
            rem_nx[i] = r2[i][SQ_OUT_W-1:0];
            q_nx[i]   = q_cur[i];
            if (r2[i] >= {1'b0, den_cur[i]})
            begin
                rem_nx[i]          = SQ_OUT_W'(r2[i] - {1'b0, den_cur[i]});
                q_nx[i][STEPS-1-i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                rem_reg[i] <= rem_nx[i];
                low_reg[i] <= low_cur[i];
                q_reg[i]   <= q_nx[i];
                den_reg[i] <= den_cur[i];
                neg_reg[i] <= neg_cur[i];
            end
        end
    end

    assign quo = q_reg[STEPS-1];
    assign neg = neg_reg[STEPS-1];

endmodule

`default_nettype wire

// File: hdl/lab_to_din99_convert_top.sv
// CIELAB to DIN99 family converter: pipeline, variant register and output buffer.
// Items pass stages 1 to 77, the first loaded at acceptance, and then the output register;
// throughput is one item per cycle while the second entry of the output buffer is empty.
// The depth is set by the chroma path: 6 front-end stages, the 32-stage root, 2 stages,
// the 34-stage chroma log and 3 stages to the final product, one step per stage. A
// two-entry output buffer lets the pipeline run while a result waits. Reset clears
// valid bits, the output buffer flags and the variant register (DIN99).
`default_nettype none

module lab_to_din99_convert_top
    import din99_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [14:0]        lab_l,
    input  logic signed [15:0] lab_a,
    input  logic signed [15:0] lab_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [14:0]        l99,
    output logic signed [14:0] a99,
    output logic signed [14:0] b99
);

    localparam int SH_XL  = FRAC_BITS + 10;
    localparam int SH_L99 = 46 - FRAC_BITS;
    localparam int SH_XC  = FRAC_BITS + 16;
    localparam int SH_AB  = 54 - FRAC_BITS;

    // Stage where each result appears
    localparam int ST_XL    = 2;
    localparam int ST_SUM   = 6;
    localparam int ST_G     = ST_SUM + SQ_LAT;
    localparam int ST_XC    = ST_G + 2;
    localparam int ST_LNC   = ST_XC + LN_LAT;
    localparam int ST_C99   = ST_LNC + 2;
    localparam int ST_DIV   = ST_G + DIV_LAT;
    localparam int ST_LNL   = ST_XL + LN_LAT;
    localparam int ST_L99   = ST_LNL + 2;
    localparam int ST_END   = ST_C99 + 1;
    localparam int DIV_DLY  = ST_C99 - ST_DIV;
    localparam int L99_DLY  = ST_END - ST_L99;
    localparam int GZ_DLY   = ST_END - ST_G;

    function automatic logic [65:0] rnd_u(input logic [65:0] val, input int sh);
        rnd_u = (val + (66'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic signed [65:0] rnd_s(input logic signed [65:0] val,
                                                input int sh);
        logic [65:0] m;
        m = val[65] ? 66'(-val) : 66'(val);
        m = (m + (66'd1 << (sh - 1))) >> sh;
        rnd_s = val[65] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [14:0] sat_ab(input logic [65:0] m, input logic ng);
        if (ng)
        begin
            if (m > 66'(AB_MIN))
            begin
                sat_ab = AB_MIN;
            end
            else
            begin
                sat_ab = 15'(66'd0 - m);
            end
        end
        else
        begin
            if (m > 66'(AB_MAX))
            begin
                sat_ab = AB_MAX;
            end
            else
            begin
                sat_ab = m[14:0];
            end
        end
    endfunction

    // Control
    logic [1:0]        variant_reg;
    logic [ST_END-1:0] vld_reg;
    logic              adv;
    logic              pipe_valid;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    // Pipeline data
    logic [49:0]                s1_pl_reg, s1_pl_next;
    logic signed [47:0]         s1_pac_reg, s1_pac_next, s1_pbs_reg, s1_pbs_next;
    logic signed [47:0]         s1_pbc_reg, s1_pbc_next, s1_pas_reg, s1_pas_next;
    logic [LN_X_W-1:0]          s2_xl_reg, s2_xl_next;
    logic signed [32:0]         s2_e_reg, s2_e_next, s2_f0_reg, s2_f0_next;
    logic signed [64:0]         s3_pf_reg, s3_pf_next;
    logic signed [32:0]         s3_e_reg;
    logic signed [32:0]         s4_e_reg, s4_f_reg, s4_f_next;
    logic [32:0]                s4_em, s4_fm;
    logic [63:0]                s5_esq_reg, s5_esq_next, s5_fsq_reg, s5_fsq_next;
    logic signed [64:0]         s5_pec_reg, s5_pec_next, s5_pfs_reg, s5_pfs_next;
    logic signed [64:0]         s5_pes_reg, s5_pes_next, s5_pfc_reg, s5_pfc_next;
    logic [SQ_IN_W-1:0]         s6_sum_reg, s6_sum_next;
    logic signed [DIV_NUM_W-1:0] s6_e2_reg, s6_e2_next, s6_f2_reg, s6_f2_next;
    logic [SQ_OUT_W-1:0]        g_st;
    logic signed [DIV_NUM_W-1:0] e2_st, f2_st;
    logic [2*DIV_NUM_W-1:0]     ef_dly;
    logic [SQ_OUT_W-1:0]        qa_div, qb_div, qa_c, qb_c;
    logic                       na_div, nb_div, na_c, nb_c;
    logic [58:0]                s39_pg_reg, s39_pg_next;
    logic [LN_X_W-1:0]          s40_xc_reg, s40_xc_next;
    logic [LN_OUT_W-1:0]        lnc, lnl;
    logic [62:0]                s75_pc_reg, s75_pc_next;
    logic [32:0]                s76_c99_reg, s76_c99_next;
    logic [58:0]                s37_pl99_reg, s37_pl99_next;
    logic [14:0]                s38_l99_reg, s38_l99_next;
    logic [64:0]                s77_pa_reg, s77_pa_next, s77_pb_reg, s77_pb_next;
    logic                       s77_na_reg, s77_nb_reg;
    logic [14:0]                l99_end;
    logic                       gz_end;
    logic [65:0]                t_u0, t_u1, t_u2, t_u3, t_ra, t_rb;
    logic signed [65:0]         t_s0, t_s1, t_s2, t_s3, t_s4;

    // Final results and output buffer
    logic [14:0]  res_l99, res_a99, res_b99;
    logic [14:0]  out_l99_reg, out_a99_reg, out_b99_reg;
    logic [14:0]  skid_l99_reg, skid_a99_reg, skid_b99_reg;

    assign adv        = !skid_valid_reg;
    assign in_ready   = adv;
    assign pipe_valid = vld_reg[ST_END-1];

    // Variant register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= '0;
        end
        else if (cfg_we)
        begin
            variant_reg <= cfg_data;
        end
    end

    // Valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[ST_END-2:0], in_valid};
        end
    end

    // Front end: products, first rotation, f scaling, squares, hue rotation
    always_comb
    begin
        s1_pl_next  = C2_Q40[variant_reg] * lab_l;
        s1_pac_next = COS3_Q30[variant_reg] * lab_a;
        s1_pbs_next = SIN3_Q30[variant_reg] * lab_b;
        s1_pbc_next = COS3_Q30[variant_reg] * lab_b;
        s1_pas_next = SIN3_Q30[variant_reg] * lab_a;

        t_u0        = rnd_u(66'(s1_pl_reg), SH_XL);
        s2_xl_next  = t_u0[LN_X_W-1:0];
        t_s0        = rnd_s(66'(s1_pac_reg) + 66'(s1_pbs_reg), ROT_SH);
        s2_e_next   = t_s0[32:0];
        t_s1        = rnd_s(66'(s1_pbc_reg) - 66'(s1_pas_reg), ROT_SH);
        s2_f0_next  = t_s1[32:0];

        s3_pf_next  = C4_Q30[variant_reg] * s2_f0_reg;
        t_s2        = rnd_s(66'(s3_pf_reg), 30);
        s4_f_next   = t_s2[32:0];

        s4_em       = s4_e_reg[32] ? 33'(-s4_e_reg) : 33'(s4_e_reg);
        s4_fm       = s4_f_reg[32] ? 33'(-s4_f_reg) : 33'(s4_f_reg);
        s5_esq_next = 64'(s4_em[31:0]) * 64'(s4_em[31:0]);
        s5_fsq_next = 64'(s4_fm[31:0]) * 64'(s4_fm[31:0]);
        s5_pec_next = COS7_Q30[variant_reg] * s4_e_reg;
        s5_pfs_next = SIN7_Q30[variant_reg] * s4_f_reg;
        s5_pes_next = SIN7_Q30[variant_reg] * s4_e_reg;
        s5_pfc_next = COS7_Q30[variant_reg] * s4_f_reg;

        s6_sum_next = SQ_IN_W'(65'(s5_esq_reg) + 65'(s5_fsq_reg));
        t_s3        = rnd_s(66'(s5_pec_reg) - 66'(s5_pfs_reg), 30);
        s6_e2_next  = t_s3[DIV_NUM_W-1:0];
        t_s4        = rnd_s(66'(s5_pes_reg) + 66'(s5_pfc_reg), 30);
        s6_f2_next  = t_s4[DIV_NUM_W-1:0];
    end

    // Back end: chroma log argument, chroma, lightness, final products
    always_comb
    begin
        s39_pg_next   = C6_Q30[variant_reg] * g_st;
        t_u1          = rnd_u(66'(s39_pg_reg), SH_XC);
        s40_xc_next   = t_u1[LN_X_W-1:0];
        s75_pc_next   = C58_Q24[variant_reg] * lnc;
        t_u2          = rnd_u(66'(s75_pc_reg), 30);
        s76_c99_next  = t_u2[32:0];
        s37_pl99_next = C1_Q16[variant_reg] * lnl;
        t_u3          = rnd_u(66'(s37_pl99_reg), SH_L99);
        s38_l99_next  = (t_u3 > 66'(L99_MAX)) ? L99_MAX : t_u3[14:0];
        s77_pa_next   = 65'(s76_c99_reg) * 65'(qa_c);
        s77_pb_next   = 65'(s76_c99_reg) * 65'(qb_c);
    end

    // Advance pipeline data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pl_reg    <= s1_pl_next;
            s1_pac_reg   <= s1_pac_next;
            s1_pbs_reg   <= s1_pbs_next;
            s1_pbc_reg   <= s1_pbc_next;
            s1_pas_reg   <= s1_pas_next;
            s2_xl_reg    <= s2_xl_next;
            s2_e_reg     <= s2_e_next;
            s2_f0_reg    <= s2_f0_next;
            s3_pf_reg    <= s3_pf_next;
            s3_e_reg     <= s2_e_reg;
            s4_f_reg     <= s4_f_next;
            s4_e_reg     <= s3_e_reg;
            s5_esq_reg   <= s5_esq_next;
            s5_fsq_reg   <= s5_fsq_next;
            s5_pec_reg   <= s5_pec_next;
            s5_pfs_reg   <= s5_pfs_next;
            s5_pes_reg   <= s5_pes_next;
            s5_pfc_reg   <= s5_pfc_next;
            s6_sum_reg   <= s6_sum_next;
            s6_e2_reg    <= s6_e2_next;
            s6_f2_reg    <= s6_f2_next;
            s39_pg_reg   <= s39_pg_next;
            s40_xc_reg   <= s40_xc_next;
            s75_pc_reg   <= s75_pc_next;
            s76_c99_reg  <= s76_c99_next;
            s37_pl99_reg <= s37_pl99_next;
            s38_l99_reg  <= s38_l99_next;
            s77_pa_reg   <= s77_pa_next;
            s77_pb_reg   <= s77_pb_next;
            s77_na_reg   <= na_c;
            s77_nb_reg   <= nb_c;
        end
    end

    // Lightness log
    din99_ln u_ln_l (
        .clk    (clk),
        .en     (adv),
        .x      (s2_xl_reg),
        .ln_out (lnl)
    );

    // Chroma magnitude
    din99_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .v_in (s6_sum_reg),
        .root (g_st)
    );

    // Hold the rotated pair until the root is ready
    din99_delay #(
        .W     (2 * DIV_NUM_W),
        .DEPTH (SQ_LAT)
    ) u_ef_dly (
        .clk (clk),
        .en  (adv),
        .d   ({s6_e2_reg, s6_f2_reg}),
        .q   (ef_dly)
    );

    assign e2_st = ef_dly[2*DIV_NUM_W-1:DIV_NUM_W];
    assign f2_st = ef_dly[DIV_NUM_W-1:0];

    // Unit vector
    din99_div u_div_a (
        .clk (clk),
        .en  (adv),
        .num (e2_st),
        .den (g_st),
        .quo (qa_div),
        .neg (na_div)
    );

    din99_div u_div_b (
        .clk (clk),
        .en  (adv),
        .num (f2_st),
        .den (g_st),
        .quo (qb_div),
        .neg (nb_div)
    );

    din99_delay #(
        .W     (2 * SQ_OUT_W + 2),
        .DEPTH (DIV_DLY)
    ) u_div_dly (
        .clk (clk),
        .en  (adv),
        .d   ({qa_div, qb_div, na_div, nb_div}),
        .q   ({qa_c, qb_c, na_c, nb_c})
    );

    // Chroma log
    din99_ln u_ln_c (
        .clk    (clk),
        .en     (adv),
        .x      (s40_xc_reg),
        .ln_out (lnc)
    );

    // Align lightness and the zero-root flag with the last stage
    din99_delay #(
        .W     (15),
        .DEPTH (L99_DLY)
    ) u_l99_dly (
        .clk (clk),
        .en  (adv),
        .d   (s38_l99_reg),
        .q   (l99_end)
    );

    din99_delay #(
        .W     (1),
        .DEPTH (GZ_DLY)
    ) u_gz_dly (
        .clk (clk),
        .en  (adv),
        .d   (g_st == '0),
        .q   (gz_end)
    );

    // Round, saturate and drop achromatic chroma
    always_comb
    begin
        t_ra    = rnd_u(66'(s77_pa_reg), SH_AB);
        t_rb    = rnd_u(66'(s77_pb_reg), SH_AB);
        res_l99 = l99_end;
        res_a99 = gz_end ? '0 : sat_ab(t_ra, s77_na_reg);
        res_b99 = gz_end ? '0 : sat_ab(t_rb, s77_nb_reg);
    end

    // Output buffer flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg || pipe_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (pipe_valid && adv)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output buffer data
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_l99_reg <= skid_l99_reg;
                out_a99_reg <= skid_a99_reg;
                out_b99_reg <= skid_b99_reg;
            end
            else
            begin
                out_l99_reg <= res_l99;
                out_a99_reg <= res_a99;
                out_b99_reg <= res_b99;
            end
        end
        else if (adv)
        begin
            skid_l99_reg <= res_l99;
            skid_a99_reg <= res_a99;
            skid_b99_reg <= res_b99;
        end
    end

    assign out_valid = out_valid_reg;
    assign l99       = out_l99_reg;
    assign a99       = out_a99_reg;
    assign b99       = out_b99_reg;

endmodule

`default_nettype wire
